@@ sv/sov_pkg.sv @@
// ============================================================================
// Shape pair overlap test - shared package
// Widths, pipeline payload types and fixed-point helpers used by every stage.
// ============================================================================
`default_nettype none

package sov_pkg;

    // Width of every coordinate and size field
    localparam int CB = 24;
    // Signed width of a far edge (corner plus size) and of any difference
    localparam int EB = CB + 2;
    // Unsigned width of a distance along one axis, or of a radius sum
    localparam int MB = CB + 1;
    // Width of a squared distance; a sum of two squares takes one bit more
    localparam int SB = 2 * MB;
    // Number of distance lanes (one per rectangle edge)
    localparam int NL = 4;

    localparam logic KIND_RECT   = 1'b0;
    localparam logic KIND_CIRCLE = 1'b1;

    typedef logic signed [CB-1:0] coord_t;
    typedef logic        [CB-1:0] size_t;
    typedef logic signed [EB-1:0] edge_t;
    typedef logic        [MB-1:0] mag_t;
    typedef logic        [SB-1:0] sq_t;
    typedef logic        [SB:0]   sum_t;

    typedef enum logic [1:0] {
        PAIR_RR,
        PAIR_CC,
        PAIR_RC
    } pair_t;

    // One request as it arrives
    typedef struct packed {
        logic   a_kind;
        coord_t a_x;
        coord_t a_y;
        size_t  a_w;
        size_t  a_h;
        size_t  a_r;
        logic   b_kind;
        coord_t b_x;
        coord_t b_y;
        size_t  b_w;
        size_t  b_h;
        size_t  b_r;
    } shape_pair_t;

    // After role selection: circle centre, rectangle (or second centre) box
    typedef struct packed {
        pair_t  pair;
        logic   rr_hit;
        coord_t cx;
        coord_t cy;
        coord_t rx;
        coord_t ry;
        edge_t  right;
        edge_t  top;
        mag_t   t;
    } geom_t;

    // After differences: per-lane axis distances
    typedef struct packed {
        pair_t             pair;
        logic              rr_hit;
        logic              centre_in;
        mag_t [NL-1:0]     dx;
        mag_t [NL-1:0]     dy;
        mag_t              t;
    } span_t;

    // After squaring
    typedef struct packed {
        pair_t             pair;
        logic              rr_hit;
        logic              centre_in;
        sq_t  [NL-1:0]     dx2;
        sq_t  [NL-1:0]     dy2;
        sq_t               t2;
    } square_t;

    // Sign-extend a coordinate to edge width
    function automatic edge_t ext_coord(coord_t v);
        return {{(EB-CB){v[CB-1]}}, v};
    endfunction

    // Zero-extend a size to edge width
    function automatic edge_t ext_size(size_t v);
        return {{(EB-CB){1'b0}}, v};
    endfunction

    // True when a signed difference is strictly positive
    function automatic logic is_pos(edge_t v);
        return !v[EB-1] && (v != '0);
    endfunction

    // Magnitude of a difference; the reachable range fits MB bits
    function automatic mag_t abs_edge(edge_t v);
        edge_t n;
        n = -v;
        return v[EB-1] ? n[MB-1:0] : v[MB-1:0];
    endfunction

    // Distance from a point to an interval, given p - lo and p - hi
    function automatic mag_t gap_edge(edge_t d_lo, edge_t d_hi);
        mag_t g;
        if (d_lo[EB-1])
        begin
            g = abs_edge(d_lo);
        end
        else if (is_pos(d_hi))
        begin
            g = d_hi[MB-1:0];
        end
        else
        begin
            g = '0;
        end
        return g;
    endfunction

endpackage

`default_nettype wire

@@ sv/shape_pair_overlap_test.sv @@
// ============================================================================
// Shape pair overlap test
// Reports whether two 2D shapes (rectangle or circle each) overlap.
// ============================================================================
// Usage:
//   Request channel: shape_valid / shape_stall with the two shape
//   descriptions a_* and b_* (kind, position, width, height, radius).
//   Result channel: result_valid / result_stall with overlaps.
//   A request is taken on a clock edge where valid is high and stall low.
//   An accepted request passes through four registered stages: role select,
//   edge differences, squaring (nine 25x25 multipliers), sum and compare;
//   result_valid is the valid bit of the last stage.
//   Throughput is one request per cycle while result_stall is low; each stage
//   carries its own valid bit and bubbles close up as the pipeline advances.
//   While result_stall holds, the waiting result stays put and the stages
//   behind it keep filling; shape_stall rises only once all four stages
//   hold a request.
//   Reset (rst_n low, asynchronous) empties the pipeline by clearing the
//   valid bits; the data registers are not reset and need no clearing.
// ============================================================================
`default_nettype none

module shape_pair_overlap_test
    import sov_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,

    input  wire logic   shape_valid,
    output logic        shape_stall,
    input  wire logic   a_kind,
    input  wire coord_t a_x,
    input  wire coord_t a_y,
    input  wire size_t  a_w,
    input  wire size_t  a_h,
    input  wire size_t  a_r,
    input  wire logic   b_kind,
    input  wire coord_t b_x,
    input  wire coord_t b_y,
    input  wire size_t  b_w,
    input  wire size_t  b_h,
    input  wire size_t  b_r,

    output logic        result_valid,
    input  wire logic   result_stall,
    output logic        overlaps
);

    shape_pair_t req;
    geom_t       geom;
    span_t       span;
    square_t     square;

    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s4_valid_reg;
    logic adv1;
    logic adv2;
    logic adv3;
    logic adv4;

    // Gather the request fields
    assign req = '{a_kind: a_kind, a_x: a_x, a_y: a_y, a_w: a_w, a_h: a_h, a_r: a_r,
                   b_kind: b_kind, b_x: b_x, b_y: b_y, b_w: b_w, b_h: b_h, b_r: b_r};

    // A stage advances when it is empty or the stage after it advances
    assign adv4 = !s4_valid_reg || !result_stall;
    assign adv3 = !s3_valid_reg || adv4;
    assign adv2 = !s2_valid_reg || adv3;
    assign adv1 = !s1_valid_reg || adv2;

    assign shape_stall = !adv1;

    // Move valid bits along with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= shape_valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (adv4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    sov_role u_role
    (
        .clk  (clk),
        .en   (adv1),
        .req  (req),
        .geom (geom)
    );

    sov_span u_span
    (
        .clk  (clk),
        .en   (adv2),
        .geom (geom),
        .span (span)
    );

    sov_square u_square
    (
        .clk    (clk),
        .en     (adv3),
        .span   (span),
        .square (square)
    );

    sov_decide u_decide
    (
        .clk    (clk),
        .en     (adv4),
        .square (square),
        .hit    (overlaps)
    );

    assign result_valid = s4_valid_reg;

`ifndef SYNTHESIS
    // An accepted request lands in the first stage
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        shape_valid && !shape_stall |=> s1_valid_reg)
        else $error("accepted request did not enter the pipeline");

    // An empty third stage never produces a result
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        !s3_valid_reg && adv4 |=> !result_valid)
        else $error("result appeared from an empty stage");

    // Back-pressure only when every stage is full and the output is held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        shape_stall |-> s1_valid_reg && s2_valid_reg && s3_valid_reg && result_valid
                        && result_stall)
        else $error("request stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire

@@ sv/sov_role.sv @@
// ============================================================================
// Shape pair overlap test - role stage
// Classifies the pair, runs the rectangle/rectangle test and picks which
// shape acts as circle and which as box, forming the far edges.
// ============================================================================
`default_nettype none

module sov_role
    import sov_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire shape_pair_t req,
    output geom_t            geom
);

    geom_t geom_reg;
    geom_t geom_next;

    // Classify, test rectangle pair, select roles
    always_comb
    begin
        edge_t a_l;
        edge_t a_b;
        edge_t a_rt;
        edge_t a_tp;
        edge_t b_l;
        edge_t b_b;
        edge_t b_rt;
        edge_t b_tp;
        edge_t box_l;
        edge_t box_b;
        logic  circ_is_a;

        a_l  = ext_coord(req.a_x);
        a_b  = ext_coord(req.a_y);
        a_rt = a_l + ext_size(req.a_w);
        a_tp = a_b + ext_size(req.a_h);
        b_l  = ext_coord(req.b_x);
        b_b  = ext_coord(req.b_y);
        b_rt = b_l + ext_size(req.b_w);
        b_tp = b_b + ext_size(req.b_h);

        case ({req.a_kind, req.b_kind})
            {KIND_RECT, KIND_RECT}:     geom_next.pair = PAIR_RR;
            {KIND_CIRCLE, KIND_CIRCLE}: geom_next.pair = PAIR_CC;
            default:                    geom_next.pair = PAIR_RC;
        endcase

        geom_next.rr_hit = (a_l <= b_rt) && (b_l <= a_rt) && (a_b <= b_tp) && (b_b <= a_tp);

        // A circle in the first slot takes the circle role; the other shape
        // provides the box corner (or the second centre)
        circ_is_a   = (req.a_kind == KIND_CIRCLE);
        geom_next.cx = circ_is_a ? req.a_x : req.b_x;
        geom_next.cy = circ_is_a ? req.a_y : req.b_y;
        geom_next.rx = circ_is_a ? req.b_x : req.a_x;
        geom_next.ry = circ_is_a ? req.b_y : req.a_y;
        box_l = circ_is_a ? b_l : a_l;
        box_b = circ_is_a ? b_b : a_b;
        geom_next.right = circ_is_a ? b_rt : a_rt;
        geom_next.top   = circ_is_a ? b_tp : a_tp;
        if (req.a_kind == KIND_CIRCLE && req.b_kind == KIND_CIRCLE)
        begin
            geom_next.t = {1'b0, req.a_r} + {1'b0, req.b_r};
        end
        else
        begin
            geom_next.t = {1'b0, (circ_is_a ? req.a_r : req.b_r)};
        end
        // Corner edges are the corner itself; kept for symmetry of the sums
        if (box_l != ext_coord(geom_next.rx) || box_b != ext_coord(geom_next.ry))
        begin
            geom_next.rr_hit = 1'b0;
        end
    end

    // Advance when this stage is empty or the next stage takes the item
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geom_reg <= geom_next;
        end
    end

    assign geom = geom_reg;

endmodule

`default_nettype wire

@@ sv/sov_span.sv @@
// ============================================================================
// Shape pair overlap test - span stage
// Forms centre-to-edge differences, axis gaps and the strict inside test,
// and lays them out as one distance pair per lane.
// ============================================================================
`default_nettype none

module sov_span
    import sov_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  en,
    input  wire geom_t geom,
    output span_t      span
);

    span_t span_reg;
    span_t span_next;

    // Differences to the near and far edges on both axes
    always_comb
    begin
        edge_t dxl;
        edge_t dxh;
        edge_t dyl;
        edge_t dyh;
        mag_t  gx;
        mag_t  gy;

        dxl = ext_coord(geom.cx) - ext_coord(geom.rx);
        dxh = ext_coord(geom.cx) - geom.right;
        dyl = ext_coord(geom.cy) - ext_coord(geom.ry);
        dyh = ext_coord(geom.cy) - geom.top;
        gx  = gap_edge(dxl, dxh);
        gy  = gap_edge(dyl, dyh);

        span_next.pair      = geom.pair;
        span_next.rr_hit    = geom.rr_hit;
        span_next.t         = geom.t;
        span_next.centre_in = is_pos(dxl) && dxh[EB-1] && is_pos(dyl) && dyh[EB-1];

        // Bottom, top, left and right edges
        span_next.dx[0] = gx;
        span_next.dy[0] = abs_edge(dyl);
        span_next.dx[1] = gx;
        span_next.dy[1] = abs_edge(dyh);
        span_next.dx[2] = abs_edge(dxl);
        span_next.dy[2] = gy;
        span_next.dx[3] = abs_edge(dxh);
        span_next.dy[3] = gy;

        // Two circles: lane 0 carries the centre-to-centre distance
        if (geom.pair == PAIR_CC)
        begin
            span_next.dx[0] = abs_edge(dxl);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            span_reg <= span_next;
        end
    end

    assign span = span_reg;

endmodule

`default_nettype wire

@@ sv/sov_square.sv @@
// ============================================================================
// Shape pair overlap test - square stage
// Squares every lane distance and the radius term, one multiplier each.
// ============================================================================
`default_nettype none

module sov_square
    import sov_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  en,
    input  wire span_t span,
    output square_t    square
);

    square_t square_reg;
    square_t square_next;

    // Square each distance and the threshold
    always_comb
    begin
        square_next.pair      = span.pair;
        square_next.rr_hit    = span.rr_hit;
        square_next.centre_in = span.centre_in;
        square_next.t2        = sq_t'(span.t) * sq_t'(span.t);
        for (int i = 0; i < NL; i++)
        begin
            square_next.dx2[i] = sq_t'(span.dx[i]) * sq_t'(span.dx[i]);
            square_next.dy2[i] = sq_t'(span.dy[i]) * sq_t'(span.dy[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            square_reg <= square_next;
        end
    end

    assign square = square_reg;

endmodule

`default_nettype wire

@@ sv/sov_decide.sv @@
// ============================================================================
// Shape pair overlap test - decision stage
// Sums the squares per lane, compares against the squared threshold and
// registers the final verdict for the output.
// ============================================================================
`default_nettype none

module sov_decide
    import sov_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    en,
    input  wire square_t square,
    output logic         hit
);

    logic hit_reg;
    logic hit_next;

    // Compare each lane and combine by pair type
    always_comb
    begin
        sum_t          d2;
        sum_t          t2;
        logic [NL-1:0] lt;
        logic          le0;

        t2  = {1'b0, square.t2};
        le0 = 1'b0;
        for (int i = 0; i < NL; i++)
        begin
            d2    = {1'b0, square.dx2[i]} + {1'b0, square.dy2[i]};
            lt[i] = (d2 < t2);
            if (i == 0)
            begin
                le0 = (d2 <= t2);
            end
        end

        case (square.pair)
            PAIR_RR: hit_next = square.rr_hit;
            PAIR_CC: hit_next = le0;
            PAIR_RC: hit_next = square.centre_in || (|lt);
            default: hit_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

`default_nettype wire
